// ===== src/hed_pkg.sv =====
// Shared types, character codes and helper functions for the HTML entity decoder.
// Used by hed_lookahead, hed_accum and html_entity_decoder_core.
// Depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package hed_pkg;

  // Default sizes.
  localparam int MAX_REF_SPAN_DEF = 12;
  localparam int MAX_CAPACITY_DEF = 4096;

  // Fixed widths of the item fields and the capacity register.
  localparam int CFG_W  = 13;
  localparam int BYTE_W = 8;
  localparam int VAL_W  = 32;

  localparam logic [CFG_W-1:0] CAP_RESET = 13'd256;

  // Character codes.
  localparam logic [7:0] CH_NUL  = 8'h00;
  localparam logic [7:0] CH_AMP  = 8'h26;
  localparam logic [7:0] CH_SEMI = 8'h3B;
  localparam logic [7:0] CH_HASH = 8'h23;
  localparam logic [7:0] CH_LT   = 8'h3C;
  localparam logic [7:0] CH_GT   = 8'h3E;
  localparam logic [7:0] CH_QUOT = 8'h22;
  localparam logic [7:0] CH_APOS = 8'h27;
  localparam logic [7:0] CH_D0   = 8'h30;
  localparam logic [7:0] CH_D9   = 8'h39;
  localparam logic [7:0] CH_UA   = 8'h41;
  localparam logic [7:0] CH_UF   = 8'h46;
  localparam logic [7:0] CH_UX   = 8'h58;
  localparam logic [7:0] CH_UZ   = 8'h5A;
  localparam logic [7:0] CH_LA   = 8'h61;
  localparam logic [7:0] CH_LF   = 8'h66;
  localparam logic [7:0] CH_LG   = 8'h67;
  localparam logic [7:0] CH_LL   = 8'h6C;
  localparam logic [7:0] CH_LM   = 8'h6D;
  localparam logic [7:0] CH_LO   = 8'h6F;
  localparam logic [7:0] CH_LP   = 8'h70;
  localparam logic [7:0] CH_LQ   = 8'h71;
  localparam logic [7:0] CH_LS   = 8'h73;
  localparam logic [7:0] CH_LT_T = 8'h74;
  localparam logic [7:0] CH_LU   = 8'h75;
  localparam logic [7:0] CH_LX   = 8'h78;

  // Control of the lookahead buffer.
  typedef struct packed {
    logic clear;
    logic append;
    logic drop;
  } la_ctrl_t;

  // Control of the shared accumulate unit.
  typedef struct packed {
    logic       clear;
    logic       step;
    logic       hex;
    logic [3:0] digit;
  } acc_ctrl_t;

  // Returns {valid, value} for a decimal or hex digit character.
  function automatic logic [4:0] digit_decode(input logic [7:0] c, input logic hex);
    logic [7:0] d;
    logic       ok;
    ok = 1'b0;
    d  = 8'h00;
    if (c >= CH_D0 && c <= CH_D9) begin
      ok = 1'b1;
      d  = c - CH_D0;
    end else if (hex && c >= CH_LA && c <= CH_LF) begin
      ok = 1'b1;
      d  = c - CH_LA + 8'd10;
    end else if (hex && c >= CH_UA && c <= CH_UF) begin
      ok = 1'b1;
      d  = c - CH_UA + 8'd10;
    end
    return {ok, d[3:0]};
  endfunction

  // UTF-8 length of a code point, minus one.
  function automatic logic [1:0] utf8_len(input logic [VAL_W-1:0] v);
    logic [1:0] r;
    if (v < 32'h80) begin
      r = 2'd0;
    end else if (v < 32'h800) begin
      r = 2'd1;
    end else if (v < 32'h10000) begin
      r = 2'd2;
    end else begin
      r = 2'd3;
    end
    return r;
  endfunction

  // One byte of the UTF-8 sequence; the lead byte keeps only its low 8 bits.
  function automatic logic [7:0] utf8_byte(input logic [VAL_W-1:0] v,
                                           input logic [1:0] lenm1,
                                           input logic [1:0] idx);
    logic [7:0] r;
    logic [1:0] rem;
    rem = lenm1 - idx;
    if (idx == 2'd0) begin
      case (lenm1)
        2'd0:    r = v[7:0];
        2'd1:    r = 8'hC0 | v[13:6];
        2'd2:    r = 8'hE0 | v[19:12];
        default: r = 8'hF0 | v[25:18];
      endcase
    end else begin
      case (rem)
        2'd0:    r = {2'b10, v[5:0]};
        2'd1:    r = {2'b10, v[11:6]};
        2'd2:    r = {2'b10, v[17:12]};
        default: r = {2'b10, v[23:18]};
      endcase
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== src/hed_lookahead.sv =====
// Lookahead buffer of pending input bytes with semicolon search and named
// reference matching. Depends on hed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hed_lookahead #(
  parameter int MAX_REF_SPAN = hed_pkg::MAX_REF_SPAN_DEF,
  localparam int LA_DEPTH = MAX_REF_SPAN + 1,
  localparam int CNT_W = $clog2(LA_DEPTH + 1),
  localparam int IDX_W = $clog2(LA_DEPTH)
) (
  input  wire  logic               clk,
  input  wire  logic               rst,
  input  wire  hed_pkg::la_ctrl_t  ctrl,
  input  wire  logic [7:0]         wr_byte,
  input  wire  logic [IDX_W-1:0]   rd_idx,
  output logic [7:0]               rd_byte,
  output logic [7:0]               head_byte,
  output logic [7:0]               second_byte,
  output logic [7:0]               third_byte,
  output logic [CNT_W-1:0]         count,
  output logic                     semi_found,
  output logic [IDX_W-1:0]         semi_idx,
  output logic                     named_hit,
  output logic [7:0]               named_val
);

  import hed_pkg::*;

  logic [7:0] slots [LA_DEPTH];
  logic [7:0] low1, low2, low3, low4;

  function automatic logic [7:0] to_lower(input logic [7:0] c);
    return (c >= CH_UA && c <= CH_UZ) ? c + 8'd32 : c;
  endfunction

  // Byte storage: append at the tail, drop shifts everything down by one.
  always_ff @(posedge clk) begin
    if (ctrl.append) begin
      slots[count[IDX_W-1:0]] <= wr_byte;
    end else if (ctrl.drop) begin
      for (int i = 0; i < LA_DEPTH - 1; i++) begin
        slots[i] <= slots[i+1];
      end
    end
  end

  // Fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
    end else if (ctrl.clear) begin
      count <= '0;
    end else if (ctrl.append) begin
      count <= count + CNT_W'(1);
    end else if (ctrl.drop) begin
      count <= count - CNT_W'(1);
    end
  end

  assign rd_byte     = slots[rd_idx];
  assign head_byte   = slots[0];
  assign second_byte = slots[1];
  assign third_byte  = slots[2];

  // First semicolon after the leading byte, among the filled slots.
  always_comb begin
    semi_found = 1'b0;
    semi_idx   = '0;
    for (int i = LA_DEPTH - 1; i >= 1; i--) begin
      if (CNT_W'(i) < count && slots[i] == CH_SEMI) begin
        semi_found = 1'b1;
        semi_idx   = IDX_W'(i);
      end
    end
  end

  // Named references, matched without regard to case.
  always_comb begin
    low1 = to_lower(slots[1]);
    low2 = to_lower(slots[2]);
    low3 = to_lower(slots[3]);
    low4 = to_lower(slots[4]);
    named_hit = 1'b1;
    named_val = CH_AMP;
    if (semi_idx == IDX_W'(4) && low1 == CH_LA && low2 == CH_LM && low3 == CH_LP) begin
      named_val = CH_AMP;
    end else if (semi_idx == IDX_W'(3) && low1 == CH_LL && low2 == CH_LT_T) begin
      named_val = CH_LT;
    end else if (semi_idx == IDX_W'(3) && low1 == CH_LG && low2 == CH_LT_T) begin
      named_val = CH_GT;
    end else if (semi_idx == IDX_W'(5) && low1 == CH_LQ && low2 == CH_LU &&
                 low3 == CH_LO && low4 == CH_LT_T) begin
      named_val = CH_QUOT;
    end else if (semi_idx == IDX_W'(5) && low1 == CH_LA && low2 == CH_LP &&
                 low3 == CH_LO && low4 == CH_LS) begin
      named_val = CH_APOS;
    end else begin
      named_hit = 1'b0;
    end
  end

endmodule

`default_nettype wire

// ===== src/hed_accum.sv =====
// Shared accumulate unit for numeric references: value = value * base + digit,
// one digit per cycle, wrapping at 32 bits. Depends on hed_pkg.
`timescale 1ns / 1ps
`default_nettype none

module hed_accum (
  input  wire  logic                    clk,
  input  wire  hed_pkg::acc_ctrl_t      ctrl,
  output logic [hed_pkg::VAL_W-1:0]     value
);

  import hed_pkg::*;

  // Times ten is two shifted copies added; times sixteen is a plain shift.
  always_ff @(posedge clk) begin
    if (ctrl.clear) begin
      value <= '0;
    end else if (ctrl.step) begin
      if (ctrl.hex) begin
        value <= {value[VAL_W-5:0], ctrl.digit};
      end else begin
        value <= (value << 3) + (value << 1) + VAL_W'(ctrl.digit);
      end
    end
  end

endmodule

`default_nettype wire

// ===== src/html_entity_decoder_core.sv =====
// HTML character reference decoder: one byte in, decoded UTF-8 bytes out.
// A plain byte is accepted, then emitted. A decided named reference emits its
// character; a numeric one accumulates its digits, then emits its UTF-8 bytes.
// A failed '&' replays each buffered byte. Output stalls hold the sequencer.
// Synchronous reset clears the buffer fill, the emitted count and the output
// valid, and sets the capacity to 256.
`timescale 1ns / 1ps
`default_nettype none

module html_entity_decoder_core #(
  parameter int MAX_REF_SPAN = hed_pkg::MAX_REF_SPAN_DEF,
  parameter int MAX_CAPACITY = hed_pkg::MAX_CAPACITY_DEF
) (
  input  wire  logic                      clk,
  input  wire  logic                      rst,
  input  wire  logic                      cfg_we,
  input  wire  logic [hed_pkg::CFG_W-1:0] cfg_wdata,  // out_capacity
  input  wire  logic                      s_tvalid,
  output logic                            s_tready,
  input  wire  logic [7:0]                s_tdata,    // [7:0] in_byte
  input  wire  logic                      s_tlast,    // in_last
  output logic                            m_tvalid,
  input  wire  logic                      m_tready,
  output logic [7:0]                      m_tdata,    // [7:0] out_byte
  output logic                            m_tlast     // out_end
);

  import hed_pkg::*;

  localparam int LA_DEPTH = MAX_REF_SPAN + 1;
  localparam int CNT_W    = $clog2(LA_DEPTH + 1);
  localparam int IDX_W    = $clog2(LA_DEPTH);
  localparam int EMIT_W   = $clog2(MAX_CAPACITY);
  localparam int CAP_W    = $clog2(MAX_CAPACITY + 1);
  localparam int CMP_W    = ((CAP_W > CFG_W) ? CAP_W : CFG_W) + 1;

  typedef enum logic [5:0] {
    ST_IDLE    = 6'b000001,
    ST_RESOLVE = 6'b000010,
    ST_NUM     = 6'b000100,
    ST_UTF8    = 6'b001000,
    ST_DROP    = 6'b010000,
    ST_TERM    = 6'b100000
  } state_t;

  state_t            state, state_next, finish_state;
  logic [CFG_W-1:0]  capacity;
  logic [CMP_W-1:0]  cap_wide, cap_eff;
  logic [EMIT_W-1:0] emitted, emitted_next;
  logic              room, can_emit;

  logic              last_flag, last_next;
  logic [IDX_W-1:0]  semi_pos, semi_next;
  logic [IDX_W-1:0]  dig_pos, dpos_next;
  logic              hex_mode, hex_next, hex_now;
  logic              any_digit, any_next;
  logic [CNT_W-1:0]  drop_left, drop_next;
  logic [1:0]        utf_idx, uidx_next, utf_len;

  la_ctrl_t          la_ctrl;
  acc_ctrl_t         acc_ctrl;
  logic [7:0]        rd_byte, head_byte, second_byte, third_byte, named_val;
  logic [CNT_W-1:0]  la_count;
  logic              semi_found, named_hit;
  logic [IDX_W-1:0]  semi_idx;
  logic [VAL_W-1:0]  acc_value;
  logic [4:0]        dig;

  logic              emit_valid, emit_end;
  logic [7:0]        emit_byte;

  hed_lookahead #(
    .MAX_REF_SPAN(MAX_REF_SPAN)
  ) u_la (
    .clk        (clk),
    .rst        (rst),
    .ctrl       (la_ctrl),
    .wr_byte    (s_tdata),
    .rd_idx     (dig_pos),
    .rd_byte    (rd_byte),
    .head_byte  (head_byte),
    .second_byte(second_byte),
    .third_byte (third_byte),
    .count      (la_count),
    .semi_found (semi_found),
    .semi_idx   (semi_idx),
    .named_hit  (named_hit),
    .named_val  (named_val)
  );

  hed_accum u_acc (
    .clk  (clk),
    .ctrl (acc_ctrl),
    .value(acc_value)
  );

  // Capacity register and its effective value (zero acts as one, saturates).
  always_ff @(posedge clk) begin
    if (rst) begin
      capacity <= CAP_RESET;
    end else if (cfg_we) begin
      capacity <= cfg_wdata;
    end
  end

  always_comb begin
    cap_wide = CMP_W'(capacity);
    if (cap_wide == '0) begin
      cap_eff = CMP_W'(1);
    end else if (cap_wide > CMP_W'(MAX_CAPACITY)) begin
      cap_eff = CMP_W'(MAX_CAPACITY);
    end else begin
      cap_eff = cap_wide;
    end
  end

  assign room     = (CMP_W'(emitted) + CMP_W'(1)) < cap_eff;
  assign can_emit = !m_tvalid || m_tready;
  assign s_tready = (state == ST_IDLE);
  assign dig      = digit_decode(rd_byte, hex_mode);
  assign utf_len  = utf8_len(acc_value);
  assign hex_now  = (third_byte == CH_LX) || (third_byte == CH_UX);

  // Sequencer.
  always_comb begin
    state_next   = state;
    last_next    = last_flag;
    semi_next    = semi_pos;
    dpos_next    = dig_pos;
    hex_next     = hex_mode;
    any_next     = any_digit;
    drop_next    = drop_left;
    uidx_next    = utf_idx;
    emitted_next = emitted;
    la_ctrl      = '0;
    acc_ctrl     = '0;
    emit_valid   = 1'b0;
    emit_end     = 1'b0;
    emit_byte    = CH_NUL;
    finish_state = last_flag ? ST_TERM : ST_IDLE;

    case (state)
      ST_IDLE: begin
        if (s_tvalid) begin
          last_next = s_tlast;
          if (room) begin
            la_ctrl.append = 1'b1;
            state_next     = ST_RESOLVE;
          end else begin
            la_ctrl.clear = 1'b1;
            if (s_tlast) begin
              state_next = ST_TERM;
            end
          end
        end
      end

      ST_RESOLVE: begin
        if (la_count == '0) begin
          state_next = finish_state;
        end else if (!room) begin
          la_ctrl.clear = 1'b1;
          state_next    = finish_state;
        end else if (head_byte != CH_AMP) begin
          // Ordinary byte passes straight through.
          if (can_emit) begin
            emit_valid   = 1'b1;
            emit_byte    = head_byte;
            la_ctrl.drop = 1'b1;
            if (la_count == CNT_W'(1)) begin
              state_next = finish_state;
            end
          end
        end else if (semi_found) begin
          if (named_hit) begin
            if (can_emit) begin
              emit_valid = 1'b1;
              emit_byte  = named_val;
              drop_next  = CNT_W'(semi_idx) + CNT_W'(1);
              state_next = ST_DROP;
            end
          end else if (semi_idx >= IDX_W'(2) && second_byte == CH_HASH) begin
            semi_next       = semi_idx;
            hex_next        = hex_now;
            dpos_next       = hex_now ? IDX_W'(3) : IDX_W'(2);
            any_next        = 1'b0;
            acc_ctrl.clear  = 1'b1;
            state_next      = ST_NUM;
          end else if (can_emit) begin
            emit_valid   = 1'b1;
            emit_byte    = CH_AMP;
            la_ctrl.drop = 1'b1;
          end
        end else if (la_count < CNT_W'(LA_DEPTH) && !last_flag) begin
          // Undecided reference: wait for more bytes.
          state_next = ST_IDLE;
        end else if (can_emit) begin
          emit_valid   = 1'b1;
          emit_byte    = CH_AMP;
          la_ctrl.drop = 1'b1;
          if (la_count == CNT_W'(1)) begin
            state_next = finish_state;
          end
        end
      end

      ST_NUM: begin
        if (dig_pos < semi_pos) begin
          if (dig[4]) begin
            acc_ctrl.step  = 1'b1;
            acc_ctrl.hex   = hex_mode;
            acc_ctrl.digit = dig[3:0];
            dpos_next      = dig_pos + IDX_W'(1);
            any_next       = 1'b1;
          end else if (can_emit) begin
            emit_valid   = 1'b1;
            emit_byte    = CH_AMP;
            la_ctrl.drop = 1'b1;
            state_next   = ST_RESOLVE;
          end
        end else if (!any_digit || acc_value == '0) begin
          if (can_emit) begin
            emit_valid   = 1'b1;
            emit_byte    = CH_AMP;
            la_ctrl.drop = 1'b1;
            state_next   = ST_RESOLVE;
          end
        end else begin
          uidx_next  = 2'd0;
          state_next = ST_UTF8;
        end
      end

      ST_UTF8: begin
        // Bytes past the end of the room are skipped.
        if (!room || can_emit) begin
          if (room) begin
            emit_valid = 1'b1;
            emit_byte  = utf8_byte(acc_value, utf_len, utf_idx);
          end
          if (utf_idx == utf_len) begin
            drop_next  = CNT_W'(semi_pos) + CNT_W'(1);
            state_next = ST_DROP;
          end else begin
            uidx_next = utf_idx + 2'd1;
          end
        end
      end

      ST_DROP: begin
        la_ctrl.drop = 1'b1;
        drop_next    = drop_left - CNT_W'(1);
        if (drop_left == CNT_W'(1)) begin
          state_next = ST_RESOLVE;
        end
      end

      ST_TERM: begin
        if (can_emit) begin
          emit_valid    = 1'b1;
          emit_end      = 1'b1;
          emit_byte     = CH_NUL;
          la_ctrl.clear = 1'b1;
          emitted_next  = '0;
          state_next    = ST_IDLE;
        end
      end

      default: begin
        state_next = ST_IDLE;
      end
    endcase

    if (emit_valid && !emit_end) begin
      emitted_next = emitted + EMIT_W'(1);
    end
  end

  // Sequencer registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      emitted <= '0;
    end else begin
      state   <= state_next;
      emitted <= emitted_next;
    end
    last_flag <= last_next;
    semi_pos  <= semi_next;
    dig_pos   <= dpos_next;
    hex_mode  <= hex_next;
    any_digit <= any_next;
    drop_left <= drop_next;
    utf_idx   <= uidx_next;
  end

  // Output register holds one result item until it is taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (emit_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
    if (emit_valid) begin
      m_tdata <= emit_byte;
      m_tlast <= emit_end;
    end
  end

endmodule

`default_nettype wire
